// ===== sv/tsp_pkg.sv =====
`default_nettype none

package tsp_pkg;

   localparam int unsigned PID_W       = 13;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned PCOUNT_W    = 8;
   localparam int unsigned CC_W        = 4;
   localparam int unsigned GROUP_W     = 4;

   localparam logic [PCOUNT_W-1:0] PAYLOAD_BYTES = 8'd184;
   localparam logic [GROUP_W-1:0]  TS_PER_GROUP  = 4'd7;

   localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h47;
   localparam logic [BYTE_W-1:0] CC_BASE    = 8'h10;
   localparam logic [BYTE_W-1:0] PUSI_BIT   = 8'h40;

   // output phase of one input transaction: four header bytes, then the data byte
   localparam int unsigned PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_SYNC   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_PID_HI = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PID_LO = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CC     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;

endpackage

`default_nettype wire

// ===== sv/tsp_req_if.sv =====
`default_nettype none

interface tsp_req_if
   import tsp_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              section_end;

   modport source (output valid, output data_byte, output section_end, input ready);
   modport sink   (input valid, input data_byte, input section_end, output ready);
endinterface

`default_nettype wire

// ===== sv/tsp_rsp_if.sv =====
`default_nettype none

interface tsp_rsp_if
   import tsp_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              packet_start;
   logic              packet_end;
   logic              group_start;
   logic              last;

   modport source (output valid, output out_byte, output packet_start, output packet_end,
                   output group_start, output last, input ready);
   modport sink   (input valid, input out_byte, input packet_start, input packet_end,
                   input group_start, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/tsp_csr_if.sv =====
`default_nettype none

interface tsp_csr_if
   import tsp_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [PID_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ts_section_packetizer_unit.sv =====
`default_nettype none

// Section-to-transport-stream packetizer. Each req transaction carries one
// section byte; the unit answers with one rsp transaction for that byte, or
// five when the byte opens a packet (sync 0x47, start-indicator/PID-high,
// PID-low, 0x10|continuity counter, then the byte). A packet closes after 184
// payload bytes or on section_end; the short last packet is not padded, and
// the continuity counter and grouping restart with each section. group_start
// marks the sync byte of every TS_PER_GROUP-th packet of a section, counting
// from the first. Throughput follows the output side: one rsp transaction per
// cycle while rsp_port.ready is high and section bytes keep arriving. The
// single current-transaction register is refilled in the same cycle its data
// byte is handed to the output register, so bytes stream back to back without
// a bubble. Write stream_pid through csr only while the unit is idle; it is
// used for every header emitted afterwards. Reset is synchronous, active high.
module ts_section_packetizer_unit
   import tsp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   tsp_req_if.sink     req_port,
   tsp_rsp_if.source   rsp_port,
   tsp_csr_if.sink     csr_port
);

   // configuration
   logic [PID_W-1:0] pid_ff;

   // section state, updated when a transaction is taken in
   logic [PCOUNT_W-1:0] pcount_ff, pcount_in;
   logic [CC_W-1:0]     cc_ff, cc_in;
   logic [GROUP_W-1:0]  group_ff, group_in;
   logic                sfirst_ff, sfirst_in;

   // current transaction being expanded into output bytes
   logic                cur_vld_ff, cur_vld_in;
   logic [BYTE_W-1:0]   cur_byte_ff;
   logic                cur_pend_ff;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [CC_W-1:0]     hdr_cc_ff;
   logic                hdr_pusi_ff;
   logic                hdr_gs_ff;

   // output register
   logic                rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_ps_ff, rsp_ps_in;
   logic                rsp_pe_ff, rsp_pe_in;
   logic                rsp_gs_ff, rsp_gs_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                emit;
   logic                done;
   logic                take;
   logic                need_hdr;
   logic                pend;
   logic [PCOUNT_W-1:0] pcount_inc;
   logic [GROUP_W-1:0]  group_inc;

   assign csr_port.ready = 1'b1;

   assign out_free = !rsp_vld_ff || rsp_port.ready;
   assign emit     = cur_vld_ff && out_free;
   assign done     = emit && (phase_ff == PH_DATA);
   assign req_port.ready = !cur_vld_ff || done;
   assign take     = req_port.valid && req_port.ready;

   // model step, evaluated on the incoming transaction
   assign need_hdr   = (pcount_ff == '0);
   assign pcount_inc = pcount_ff + 1'b1;
   assign group_inc  = group_ff + 1'b1;
   assign pend       = req_port.section_end || (pcount_inc >= PAYLOAD_BYTES);

   always_comb begin
      pcount_in = pcount_ff;
      cc_in     = cc_ff;
      group_in  = group_ff;
      sfirst_in = sfirst_ff;
      if (take) begin
         if (need_hdr) begin
            cc_in     = cc_ff + 1'b1;
            sfirst_in = 1'b0;
            group_in  = (group_inc >= TS_PER_GROUP) ? '0 : group_inc;
         end
         pcount_in = pend ? '0 : pcount_inc;
         if (req_port.section_end) begin
            cc_in     = '0;
            group_in  = '0;
            sfirst_in = 1'b1;
         end
      end
   end

   always_comb begin
      cur_vld_in = cur_vld_ff;
      phase_in   = phase_ff;
      if (take) begin
         cur_vld_in = 1'b1;
         phase_in   = need_hdr ? PH_SYNC : PH_DATA;
      end else if (done) begin
         cur_vld_in = 1'b0;
      end else if (emit) begin
         phase_in = phase_ff + 1'b1;
      end
   end

   // byte selection for the current phase
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_ps_in   = rsp_ps_ff;
      rsp_pe_in   = rsp_pe_ff;
      rsp_gs_in   = rsp_gs_ff;
      rsp_last_in = rsp_last_ff;
      if (out_free) begin
         rsp_vld_in  = cur_vld_ff;
         rsp_ps_in   = 1'b0;
         rsp_pe_in   = 1'b0;
         rsp_gs_in   = 1'b0;
         rsp_last_in = 1'b0;
         unique case (phase_ff)
            PH_SYNC: begin
               rsp_byte_in = SYNC_BYTE;
               rsp_ps_in   = 1'b1;
               rsp_gs_in   = hdr_gs_ff;
            end
            PH_PID_HI: begin
               rsp_byte_in = (hdr_pusi_ff ? PUSI_BIT : '0)
                             | {3'b000, pid_ff[PID_W-1:BYTE_W]};
            end
            PH_PID_LO: begin
               rsp_byte_in = pid_ff[BYTE_W-1:0];
            end
            PH_CC: begin
               rsp_byte_in = CC_BASE | {{(BYTE_W-CC_W){1'b0}}, hdr_cc_ff};
            end
            default: begin
               rsp_byte_in = cur_byte_ff;
               rsp_pe_in   = cur_pend_ff;
               rsp_last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff     <= '0;
         pcount_ff  <= '0;
         cc_ff      <= '0;
         group_ff   <= '0;
         sfirst_ff  <= 1'b1;
         cur_vld_ff <= 1'b0;
         phase_ff   <= PH_SYNC;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_port.valid) begin
            pid_ff <= csr_port.data;
         end
         pcount_ff  <= pcount_in;
         cc_ff      <= cc_in;
         group_ff   <= group_in;
         sfirst_ff  <= sfirst_in;
         cur_vld_ff <= cur_vld_in;
         phase_ff   <= phase_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         cur_byte_ff <= req_port.data_byte;
         cur_pend_ff <= pend;
         hdr_cc_ff   <= cc_ff;
         hdr_pusi_ff <= sfirst_ff;
         hdr_gs_ff   <= (group_ff == '0);
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_ps_ff   <= rsp_ps_in;
      rsp_pe_ff   <= rsp_pe_in;
      rsp_gs_ff   <= rsp_gs_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_port.valid        = rsp_vld_ff;
   assign rsp_port.out_byte     = rsp_byte_ff;
   assign rsp_port.packet_start = rsp_ps_ff;
   assign rsp_port.packet_end   = rsp_pe_ff;
   assign rsp_port.group_start  = rsp_gs_ff;
   assign rsp_port.last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_pcount_range: assert property (@(posedge clock) disable iff (reset)
      pcount_ff < PAYLOAD_BYTES)
      else $error("payload count reached packet size");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      (emit && (phase_ff != PH_DATA)) |=> (cur_vld_ff && (phase_ff == $past(phase_ff) + 1'b1)))
      else $error("header phase did not advance");

   a_gs_on_sync: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_gs_ff) |-> (rsp_ps_ff && !rsp_last_ff))
      else $error("group start outside a sync byte");

   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      (take && cur_vld_ff) |-> (phase_ff == PH_DATA && out_free))
      else $error("transaction taken over unfinished one");
`endif

endmodule

`default_nettype wire
